>>> src/lfcd_pkg.sv
package lfcd_pkg;

  localparam int DEPTH         = 1024;
  localparam int PAYLOAD_WIDTH = 32;
  localparam int ADDR_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W         = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_ENQ  = 2'd0,
    REQ_DEQ  = 2'd1,
    REQ_TICK = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_DROPPED   = 3'd1,
    ST_DELIVERED = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_BLOCKED   = 3'd4,
    ST_TICK      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CS_UNDET   = 2'd0,
    CS_NONCONG = 2'd1,
    CS_CONG    = 2'd2
  } cs_t;

  typedef enum logic [2:0] {
    REG_CAPACITY   = 3'd0,
    REG_PAUSE      = 3'd1,
    REG_RESUME     = 3'd2,
    REG_LONG       = 3'd3,
    REG_MIN_CLEAR  = 3'd4,
    REG_SAMPLE_IVL = 3'd5
  } reg_idx_t;

  // ternary detector step, taken on each delivery
  function automatic cs_t cong_step(cs_t cur, logic on, logic lng, logic fell);
    cs_t ns;
    ns = cur;
    case (cur)
      CS_NONCONG: begin
        if (on && lng) ns = CS_CONG;
        if (!on) ns = CS_UNDET;
      end
      CS_CONG: begin
        if (on && !lng) ns = CS_NONCONG;
        if (!on) ns = CS_UNDET;
      end
      default: begin
        if (on && (fell || !lng)) ns = CS_NONCONG;
        if (on && !fell && lng) ns = CS_CONG;
      end
    endcase
    return ns;
  endfunction

endpackage

>>> src/lfcd_ram.sv
module lfcd_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

>>> src/lossless_fifo_congestion_detector.sv
// channel | dir | tdata (low bit up)                          | tuser (low bit up)
// s_      | in  | payload[31:0]                               | req_type[1:0], next_hop_paused[2]
// m_      | out | out_payload[31:0], congestion_state[33:32], | status[2:0]
//         |     | upstream_on[34], occupancy[45:35],          |
//         |     | zero[47:46]                                 |
// apb     | in  | register i at byte address 4*i, 32-bit data | -
// every request but a delivered dequeue writes its result straight into the output register;
// a delivered dequeue waits on the registered read of the item memory at the head pointer.
// a new item is taken while no delivery read is pending and the output register is empty
// or being drained, so a stalled m_ side holds at most one result and then holds back s_.
// rst is synchronous: pointers, count, timers and detector clear, senders allowed,
// registers return to their defaults. the item memory itself is not cleared.
module lossless_fifo_congestion_detector (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // payload
  input  logic [2:0]  s_tuser,   // req_type, next_hop_paused
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // out_payload, congestion_state, upstream_on, occupancy
  output logic [2:0]  m_tuser,   // status
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = lfcd_pkg::ADDR_W;
  localparam int CW = lfcd_pkg::CNT_W;
  localparam int PW = lfcd_pkg::PAYLOAD_WIDTH;

  // configuration
  logic [10:0] capacity, pause_above, resume_at_or_below, long_queue_threshold;
  logic [31:0] min_clear_ticks;
  logic [15:0] sample_interval;

  // queue state
  logic [AW-1:0] head_ptr, tail_ptr;
  logic [CW-1:0] item_count;
  lfcd_pkg::cs_t detect_state;
  logic          queue_blocked;
  logic [31:0]   clear_ticks;
  logic [15:0]   sample_ticks;
  logic [CW-1:0] last_size;
  logic          size_fell;
  logic          upstream_flag;

  // result register
  logic                pend;
  lfcd_pkg::status_t   res_status;
  logic [31:0]         res_payload;
  lfcd_pkg::cs_t       res_cs;
  logic                res_up;
  logic [10:0]         res_occ;

  logic [PW-1:0] rd_data;

  lfcd_pkg::req_t req;
  logic           paused;
  logic           take;
  logic           cfg_wr;
  logic [2:0]     cfg_idx;

  assign req     = lfcd_pkg::req_t'(s_tuser[1:0]);
  assign paused  = s_tuser[2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  assign s_tready = !pend && (!m_tvalid || m_tready);
  assign take     = s_tvalid && s_tready;

  assign m_tuser = res_status;
  assign m_tdata = {2'b00, res_occ, res_up, res_cs, res_payload};

  always_comb begin
    case (cfg_idx)
      lfcd_pkg::REG_CAPACITY:   prdata = {21'd0, capacity};
      lfcd_pkg::REG_PAUSE:      prdata = {21'd0, pause_above};
      lfcd_pkg::REG_RESUME:     prdata = {21'd0, resume_at_or_below};
      lfcd_pkg::REG_LONG:       prdata = {21'd0, long_queue_threshold};
      lfcd_pkg::REG_MIN_CLEAR:  prdata = min_clear_ticks;
      lfcd_pkg::REG_SAMPLE_IVL: prdata = {16'd0, sample_interval};
      default:                  prdata = 32'd0;
    endcase
  end

  // request decode
  logic [31:0] cap_eff;
  logic        full, empty;
  logic        do_store, do_deliver;
  logic [CW-1:0] cnt_inc, cnt_dec;
  logic [31:0] clr_eff;
  logic [15:0] ivl, samp_inc;
  logic [CW-1:0] item_count_next;
  logic          upstream_flag_next;
  lfcd_pkg::cs_t detect_state_next;

  assign cap_eff    = (32'(capacity) > 32'(lfcd_pkg::DEPTH)) ? 32'(lfcd_pkg::DEPTH)
                                                             : 32'(capacity);
  assign full       = 32'(item_count) >= cap_eff;
  assign empty      = item_count == '0;
  assign do_store   = take && req == lfcd_pkg::REQ_ENQ && !full;
  assign do_deliver = take && req == lfcd_pkg::REQ_DEQ && !empty && !paused;
  assign cnt_inc    = item_count + CW'(1);
  assign cnt_dec    = item_count - CW'(1);
  assign clr_eff    = queue_blocked ? 32'd0 : clear_ticks;
  assign ivl        = (sample_interval == 16'd0) ? 16'd1 : sample_interval;
  assign samp_inc   = sample_ticks + 16'd1;

  function automatic logic [AW-1:0] wrap_inc(logic [AW-1:0] p);
    return (32'(p) + 32'd1 >= 32'(lfcd_pkg::DEPTH)) ? '0 : p + AW'(1);
  endfunction

  always_comb begin
    item_count_next    = item_count;
    upstream_flag_next = upstream_flag;
    detect_state_next  = detect_state;
    case (req)
      lfcd_pkg::REQ_ENQ: begin
        if (!full) item_count_next = cnt_inc;
        // pause check runs on the unchanged count after a drop as well
        if (32'(item_count_next) > 32'(pause_above)) upstream_flag_next = 1'b0;
      end
      lfcd_pkg::REQ_DEQ: begin
        if (!empty && !paused) begin
          item_count_next = cnt_dec;
          if (32'(cnt_dec) <= 32'(resume_at_or_below)) upstream_flag_next = 1'b1;
          detect_state_next = lfcd_pkg::cong_step(detect_state,
                                clr_eff > min_clear_ticks,
                                32'(cnt_dec) > 32'(long_queue_threshold),
                                size_fell);
        end
      end
      default: ;
    endcase
  end

  lfcd_ram #(
    .DEPTH(lfcd_pkg::DEPTH),
    .WIDTH(PW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (do_store),
    .wr_addr(tail_ptr),
    .wr_data(PW'(s_tdata)),
    .rd_en  (do_deliver),
    .rd_addr(head_ptr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity             <= 11'd1024;
      pause_above          <= 11'd768;
      resume_at_or_below   <= 11'd256;
      long_queue_threshold <= 11'd512;
      min_clear_ticks      <= 32'd1000;
      sample_interval      <= 16'd100;
    end else if (cfg_wr) begin
      case (cfg_idx)
        lfcd_pkg::REG_CAPACITY:   capacity             <= pwdata[10:0];
        lfcd_pkg::REG_PAUSE:      pause_above          <= pwdata[10:0];
        lfcd_pkg::REG_RESUME:     resume_at_or_below   <= pwdata[10:0];
        lfcd_pkg::REG_LONG:       long_queue_threshold <= pwdata[10:0];
        lfcd_pkg::REG_MIN_CLEAR:  min_clear_ticks      <= pwdata;
        lfcd_pkg::REG_SAMPLE_IVL: sample_interval      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr      <= '0;
      tail_ptr      <= '0;
      item_count    <= '0;
      detect_state  <= lfcd_pkg::CS_UNDET;
      queue_blocked <= 1'b0;
      clear_ticks   <= 32'd0;
      sample_ticks  <= 16'd0;
      last_size     <= '0;
      size_fell     <= 1'b0;
      upstream_flag <= 1'b1;
      pend          <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      // memory data for a delivery lands in the cycle after the transfer
      if (pend) begin
        m_tvalid <= 1'b1;
      end else if (take) begin
        m_tvalid <= !do_deliver;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (pend) begin
        pend        <= 1'b0;
        res_payload <= 32'(rd_data);
      end
      if (take) begin
        res_payload   <= 32'd0;
        res_cs        <= detect_state_next;
        res_up        <= upstream_flag_next;
        res_occ       <= 11'(item_count_next);
        item_count    <= item_count_next;
        upstream_flag <= upstream_flag_next;
        detect_state  <= detect_state_next;
        case (req)
          lfcd_pkg::REQ_ENQ: begin
            if (full) begin
              res_status <= lfcd_pkg::ST_DROPPED;
            end else begin
              res_status <= lfcd_pkg::ST_STORED;
              tail_ptr   <= wrap_inc(tail_ptr);
            end
          end
          lfcd_pkg::REQ_DEQ: begin
            if (empty) begin
              res_status <= lfcd_pkg::ST_EMPTY;
            end else if (paused) begin
              queue_blocked <= 1'b1;
              res_status    <= lfcd_pkg::ST_BLOCKED;
            end else begin
              res_status    <= lfcd_pkg::ST_DELIVERED;
              queue_blocked <= 1'b0;
              clear_ticks   <= clr_eff;
              head_ptr      <= wrap_inc(head_ptr);
              last_size     <= cnt_dec;
              pend          <= 1'b1;
            end
          end
          lfcd_pkg::REQ_TICK: begin
            res_status <= lfcd_pkg::ST_TICK;
            if (clear_ticks != 32'hFFFF_FFFF) clear_ticks <= clear_ticks + 32'd1;
            if (samp_inc >= ivl) begin
              size_fell    <= item_count < last_size;
              last_size    <= item_count;
              sample_ticks <= 16'd0;
            end else begin
              sample_ticks <= samp_inc;
            end
          end
          default: begin
            res_status <= lfcd_pkg::ST_TICK;
          end
        endcase
      end
    end
  end

endmodule

>>> tb/tb_lossless_fifo_congestion_detector.sv
`timescale 1ns / 1ps

module tb_lossless_fifo_congestion_detector;

  localparam int STALL_LIMIT = 3000;
  localparam int IDLE_PCT    = 21;

  typedef struct {
    lfcd_pkg::req_t req;
    logic [31:0]    pay;
    logic           paused;
  } queue_req_t;

  typedef struct {
    lfcd_pkg::status_t status;
    logic [31:0]       payload;
    lfcd_pkg::cs_t     cstate;
    logic              up;
    logic [10:0]       occ;
  } queue_resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lossless_fifo_congestion_detector dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk = ~clk;

  // shadow of the queue and detector
  logic [lfcd_pkg::PAYLOAD_WIDTH-1:0] shadow_mem [lfcd_pkg::DEPTH];
  logic [lfcd_pkg::ADDR_W-1:0] rd_ptr = '0;
  logic [lfcd_pkg::ADDR_W-1:0] wr_ptr = '0;
  logic [lfcd_pkg::CNT_W-1:0]  q_count = '0;
  lfcd_pkg::cs_t               cstate = lfcd_pkg::CS_UNDET;
  logic                        was_blocked = 1'b0;
  logic [31:0]                 clr_cnt = '0;
  logic [15:0]                 smp_cnt = '0;
  logic [lfcd_pkg::CNT_W-1:0]  prev_size = '0;
  logic                        shrank = 1'b0;
  logic                        up_ok = 1'b1;
  logic [31:0] cfg_val [6] = '{32'd1024, 32'd768, 32'd256, 32'd512, 32'd1000, 32'd100};

  queue_req_t  pending_items [$];
  queue_resp_t pending_results [$];
  queue_req_t  next_item;
  queue_req_t  taken_item;
  queue_resp_t want;
  queue_resp_t predicted;

  logic s_took = 1'b0;
  logic steady = 1'b0;
  int   errors = 0;
  int   n_accepted = 0;
  int   n_delivered = 0;
  int   n_settings = 0;
  int   stall_cycles = 0;

  function automatic logic [lfcd_pkg::ADDR_W-1:0] wrap_next(
      input logic [lfcd_pkg::ADDR_W-1:0] p);
    return (p == lfcd_pkg::ADDR_W'(lfcd_pkg::DEPTH - 1)) ? '0 : p + lfcd_pkg::ADDR_W'(1);
  endfunction

  task automatic step_queue_model(input queue_req_t it, output queue_resp_t r);
    logic [lfcd_pkg::CNT_W-1:0] cap_eff;
    logic [15:0]                ivl;
    logic                       on;
    logic                       lng;
    r.status  = lfcd_pkg::ST_TICK;
    r.payload = '0;
    case (it.req)
      lfcd_pkg::REQ_ENQ: begin
        cap_eff = (cfg_val[lfcd_pkg::REG_CAPACITY][10:0] > lfcd_pkg::DEPTH)
                  ? lfcd_pkg::CNT_W'(lfcd_pkg::DEPTH)
                  : cfg_val[lfcd_pkg::REG_CAPACITY][10:0];
        if (q_count >= cap_eff) begin
          r.status = lfcd_pkg::ST_DROPPED;
        end else begin
          shadow_mem[wr_ptr] = it.pay;
          wr_ptr = wrap_next(wr_ptr);
          q_count = q_count + lfcd_pkg::CNT_W'(1);
          r.status = lfcd_pkg::ST_STORED;
        end
        // pause check runs even when the transfer was dropped
        if (q_count > cfg_val[lfcd_pkg::REG_PAUSE][10:0]) up_ok = 1'b0;
      end
      lfcd_pkg::REQ_DEQ: begin
        if (q_count == 0) begin
          r.status = lfcd_pkg::ST_EMPTY;
        end else if (it.paused) begin
          was_blocked = 1'b1;
          r.status = lfcd_pkg::ST_BLOCKED;
        end else begin
          if (was_blocked) begin
            was_blocked = 1'b0;
            clr_cnt = '0;
          end
          r.payload = shadow_mem[rd_ptr];
          rd_ptr = wrap_next(rd_ptr);
          q_count = q_count - lfcd_pkg::CNT_W'(1);
          if (q_count <= cfg_val[lfcd_pkg::REG_RESUME][10:0]) up_ok = 1'b1;
          on  = clr_cnt > cfg_val[lfcd_pkg::REG_MIN_CLEAR];
          lng = q_count > cfg_val[lfcd_pkg::REG_LONG][10:0];
          case (cstate)
            lfcd_pkg::CS_NONCONG: begin
              if (!on) cstate = lfcd_pkg::CS_UNDET;
              else if (lng) cstate = lfcd_pkg::CS_CONG;
            end
            lfcd_pkg::CS_CONG: begin
              if (!on) cstate = lfcd_pkg::CS_UNDET;
              else if (!lng) cstate = lfcd_pkg::CS_NONCONG;
            end
            default: begin
              if (on) cstate = (lng && !shrank) ? lfcd_pkg::CS_CONG : lfcd_pkg::CS_NONCONG;
            end
          endcase
          // detector and sampler share the last size
          prev_size = q_count;
          r.status = lfcd_pkg::ST_DELIVERED;
        end
      end
      lfcd_pkg::REQ_TICK: begin
        ivl = (cfg_val[lfcd_pkg::REG_SAMPLE_IVL][15:0] == 0)
              ? 16'd1 : cfg_val[lfcd_pkg::REG_SAMPLE_IVL][15:0];
        if (clr_cnt != 32'hFFFF_FFFF) clr_cnt = clr_cnt + 32'd1;
        smp_cnt = smp_cnt + 16'd1;
        if (smp_cnt >= ivl) begin
          shrank = q_count < prev_size;
          prev_size = q_count;
          smp_cnt = '0;
        end
      end
      default: ;
    endcase
    r.cstate = cstate;
    r.up     = up_ok;
    r.occ    = q_count;
  endtask

  // driver: new transfer offered at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_took) begin
      if (pending_items.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        next_item = pending_items.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= next_item.pay;
        s_tuser  <= {next_item.paused, next_item.req};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // monitor: results checked before the new transfer is predicted
  always @(posedge clk) begin
    s_took <= !rst && s_tvalid && s_tready;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing expected, status %0d", m_tuser);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (m_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tuser);
            errors++;
          end
          if (m_tdata[31:0] !== want.payload) begin
            $error("out_payload: expected %h, got %h", want.payload, m_tdata[31:0]);
            errors++;
          end
          if (m_tdata[33:32] !== want.cstate) begin
            $error("congestion_state: expected %0d, got %0d", want.cstate, m_tdata[33:32]);
            errors++;
          end
          if (m_tdata[34] !== want.up) begin
            $error("upstream_on: expected %0d, got %0d", want.up, m_tdata[34]);
            errors++;
          end
          if (m_tdata[45:35] !== want.occ) begin
            $error("occupancy: expected %0d, got %0d", want.occ, m_tdata[45:35]);
            errors++;
          end
          if (want.status == lfcd_pkg::ST_DELIVERED) n_delivered++;
        end
      end
      if (s_tvalid && s_tready) begin
        taken_item.req    = lfcd_pkg::req_t'(s_tuser[1:0]);
        taken_item.paused = s_tuser[2];
        taken_item.pay    = s_tdata;
        step_queue_model(taken_item, predicted);
        pending_results.push_back(predicted);
        n_accepted++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic add_item(input lfcd_pkg::req_t req, input logic [31:0] pay,
                          input logic paused);
    queue_req_t it;
    it.req    = req;
    it.pay    = pay;
    it.paused = paused;
    pending_items.push_back(it);
  endtask

  // wait for every transfer to be taken and answered, then for the read pipe
  task automatic settle();
    while (!(pending_items.size() == 0 && !s_tvalid && pending_results.size() == 0))
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // write, then read back over the same select
  task automatic reg_write(input lfcd_pkg::reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_val[idx] = val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== val) begin
      $error("register %0d: expected %h, got %h", idx, val, prdata);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(input logic [31:0] cap, input logic [31:0] pause_lvl,
                           input logic [31:0] resume_lvl, input logic [31:0] long_lvl,
                           input logic [31:0] min_clear, input logic [31:0] ivl);
    settle();
    reg_write(lfcd_pkg::REG_CAPACITY, cap);
    reg_write(lfcd_pkg::REG_PAUSE, pause_lvl);
    reg_write(lfcd_pkg::REG_RESUME, resume_lvl);
    reg_write(lfcd_pkg::REG_LONG, long_lvl);
    reg_write(lfcd_pkg::REG_MIN_CLEAR, min_clear);
    reg_write(lfcd_pkg::REG_SAMPLE_IVL, ivl);
    n_settings++;
  endtask

  task automatic run_random(input int n, input int enq_pct, input int deq_pct,
                            input int hold_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < enq_pct)
        add_item(lfcd_pkg::REQ_ENQ, $urandom, 1'($urandom_range(1)));
      else if (r < enq_pct + deq_pct)
        add_item(lfcd_pkg::REQ_DEQ, $urandom, $urandom_range(99) < hold_pct);
      else if (r < 97)
        add_item(lfcd_pkg::REQ_TICK, $urandom, 1'($urandom_range(1)));
      else
        add_item(lfcd_pkg::REQ_NONE, $urandom, 1'($urandom_range(1)));
    end
    settle();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed part at the reset settings
    add_item(lfcd_pkg::REQ_DEQ, 32'h0, 1'b0);
    add_item(lfcd_pkg::REQ_DEQ, 32'h1234_5678, 1'b1);
    add_item(lfcd_pkg::REQ_NONE, 32'hFFFF_FFFF, 1'b1);
    add_item(lfcd_pkg::REQ_TICK, 32'h0, 1'b0);
    add_item(lfcd_pkg::REQ_ENQ, 32'h0000_0000, 1'b0);
    add_item(lfcd_pkg::REQ_ENQ, 32'hFFFF_FFFF, 1'b1);
    add_item(lfcd_pkg::REQ_ENQ, 32'hA5A5_A5A5, 1'b0);
    add_item(lfcd_pkg::REQ_DEQ, 32'h0, 1'b1);
    add_item(lfcd_pkg::REQ_TICK, 32'hFFFF_FFFF, 1'b1);
    add_item(lfcd_pkg::REQ_TICK, 32'h0, 1'b0);
    add_item(lfcd_pkg::REQ_DEQ, 32'h0, 1'b0);
    add_item(lfcd_pkg::REQ_DEQ, 32'hFFFF_FFFF, 1'b0);
    add_item(lfcd_pkg::REQ_DEQ, 32'h0, 1'b1);
    add_item(lfcd_pkg::REQ_DEQ, 32'h0, 1'b0);
    add_item(lfcd_pkg::REQ_DEQ, 32'h0, 1'b0);
    add_item(lfcd_pkg::REQ_TICK, 32'h5A5A_5A5A, 1'b1);
    settle();

    // small queue with a reachable detector
    configure(8, 6, 2, 4, 3, 4);
    run_random(200, 45, 35, 15);

    // zero capacity, zero sample interval, zero clear time
    configure(0, 0, 0, 0, 0, 0);
    run_random(40, 50, 30, 10);

    // stretch with no idling on either side
    configure(16, 12, 4, 8, 10, 1);
    steady = 1'b1;
    run_random(200, 40, 30, 20);
    steady = 1'b0;

    configure(1, 0, 0, 0, 2, 3);
    run_random(100, 40, 40, 10);

    // capacity above depth saturates, queue grows past the pause level
    configure(2047, 60, 20, 40, 5, 7);
    run_random(250, 60, 30, 10);

    // top of the clear-time and sample-interval ranges, queue levels at the depth
    configure(1024, 1024, 1024, 1024, 32'hFFFF_FFFF, 65535);
    run_random(100, 50, 40, 10);

    configure(12, 9, 3, 6, 0, 2);
    run_random(200, 40, 45, 15);

    settle();
    repeat (10) @(negedge clk);
    $display("run covered %0d transfers and %0d deliveries under %0d register settings,",
             n_accepted, n_delivered, n_settings);
    $display("including zero-capacity drops, a saturated capacity and a stretch with no idling");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
